// File: sv/otr_pkg.sv
// ---------------------------------------------------------------------------
// otr_pkg
// Shared types and constants of the overload transient recorder.
// ---------------------------------------------------------------------------
`default_nettype none

package otr_pkg;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CUR_W       = 20;
  localparam int unsigned MAG_W       = 19;
  localparam int unsigned STEP_W      = 16;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned PEAK_W      = 24;
  localparam int unsigned LIM_W       = 19;
  localparam int unsigned CNT_OUT_W   = 5;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;
  localparam logic [CODE_W-1:0] CODE_MAX   = 8'd255;

  typedef enum logic [2:0] {
    OP_SAMPLE  = 3'd0,
    OP_TRIGGER = 3'd1,
    OP_RD_HDR  = 3'd2,
    OP_RD_DATA = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [STEP_W-1:0] step;
  } q_req_t;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] code;
  } q_rsp_t;

endpackage

`default_nettype wire

// File: sv/overload_transient_recorder.sv
// ---------------------------------------------------------------------------
// overload_transient_recorder
// Per-output current logger with pre-trip rings, post-trip capture and a
// circular event log read newest first.
// ---------------------------------------------------------------------------
//  channel  direction  fields
//  in_      slave      op, output_index, current_ma, fault_state, limit_ma,
//                      event_index, sample_offset, read_count
//  out_     master     found (tuser), header/sample fields (tdata), last
//  cfg_     write      amp_step_ma
//
//  sample: passes through the 9-step divider of the quantizer
//  trigger: one byte a cycle through the event sample memory port;
//  header read: the header is registered in S_HDR after the transfer;
//  data read: each byte passes memory read, load and output, which stalls on out_tready
//  after reset a clearing pass over all OUTPUTS*PRE_SAMPLES entries zeroes the rings
//  in_tready is low while an item is worked on or a result waits on out_tready
// ---------------------------------------------------------------------------
`default_nettype none

module overload_transient_recorder
  import otr_pkg::*;
#(
  parameter int OUTPUTS      = 8,
  parameter int PRE_SAMPLES  = 32,
  parameter int POST_SAMPLES = 32,
  parameter int EVENTS       = 16,
  parameter int MAX_READ     = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // op[2:0] output_index[5:3] current_ma[25:6] fault_state[33:26]
  // limit_ma[52:34] event_index[56:53] sample_offset[62:57] read_count[69:63]
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // event_output[2:0] event_fault_state[10:3] event_limit_ma[29:11]
  // peak_ma[53:30] sample_byte[61:54] event_count[66:62]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // found[0]
  output logic [0:0]             out_tuser,
  output logic                   out_tlast,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [STEP_W-1:0]       cfg_data
);

  localparam int TOTAL  = PRE_SAMPLES + POST_SAMPLES;
  localparam int OW     = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int PW     = (PRE_SAMPLES > 1) ? $clog2(PRE_SAMPLES) : 1;
  localparam int SW     = (EVENTS > 1) ? $clog2(EVENTS) : 1;
  localparam int UW     = $clog2(EVENTS + 1);
  localparam int CRW    = $clog2(POST_SAMPLES + 1);
  localparam int KW     = $clog2(TOTAL + 1);
  localparam int RING_D = OUTPUTS * PRE_SAMPLES;
  localparam int RAW    = (RING_D > 1) ? $clog2(RING_D) : 1;
  localparam int ST_D   = EVENTS * TOTAL;
  localparam int SAW    = $clog2(ST_D);
  localparam int EW     = 12;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_QUANT, S_SWR, S_TCOPY, S_TZERO, S_HDR, S_DRD, S_DLOAD, S_OUT
  } state_t;

  state_t state_r;

  // input fields
  logic [2:0]        f_op;
  logic [2:0]        f_oi;
  logic [CUR_W-1:0]  f_cur;
  logic [7:0]        f_fs;
  logic [LIM_W-1:0]  f_lim;
  logic [3:0]        f_idx;
  logic [5:0]        f_off;
  logic [6:0]        f_cnt;
  assign f_op  = in_tdata[2:0];
  assign f_oi  = in_tdata[5:3];
  assign f_cur = in_tdata[25:6];
  assign f_fs  = in_tdata[33:26];
  assign f_lim = in_tdata[52:34];
  assign f_idx = in_tdata[56:53];
  assign f_off = in_tdata[62:57];
  assign f_cnt = in_tdata[69:63];

  logic [STEP_W-1:0] step_r;

  // per-output state
  logic [PW-1:0]  head_r  [OUTPUTS];
  logic           open_r  [OUTPUTS];
  logic [SW-1:0]  cslot_r [OUTPUTS];
  logic [CRW-1:0] crem_r  [OUTPUTS];

  // event log
  logic [SW-1:0]     next_slot_r;
  logic [UW-1:0]     used_r;
  logic              svalid_r [EVENTS];
  logic [2:0]        sout_r   [EVENTS];
  logic [7:0]        sfs_r    [EVENTS];
  logic [CODE_W-1:0] speak_r  [EVENTS];
  logic [LIM_W-1:0]  slim_r   [EVENTS];

  // item context
  logic [OW-1:0]     o_r;
  logic [SW-1:0]     slot_r;
  logic [PW-1:0]     rp_r;
  logic [KW-1:0]     k_r;
  logic [KW-1:0]     wk_r;
  logic              wv_r;
  logic [CODE_W-1:0] peak_acc_r;
  logic [CODE_W-1:0] code_r;
  logic [EW-1:0]     pos_r;
  logic [EW-1:0]     end_r;
  logic [RAW-1:0]    clr_r;

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_found_r;
  logic                   out_last_r;

  // memories
  logic [CODE_W-1:0] ring_mem [RING_D];
  logic [CODE_W-1:0] st_mem   [ST_D];
  logic [CODE_W-1:0] ring_q;
  logic [CODE_W-1:0] st_q;
  logic              ring_we, st_we;
  logic [RAW-1:0]    ring_wa, ring_ra;
  logic [CODE_W-1:0] ring_wd, st_wd;
  logic [SAW-1:0]    st_wa, st_ra;

  q_req_t q_req;
  q_rsp_t q_rsp;

  otr_quant u_quant (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (q_req),
    .rsp   (q_rsp)
  );

  logic accept;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  logic oi_ok;
  assign oi_ok = (32'(f_oi) < 32'(OUTPUTS));

  assign q_req.start = accept && (op_t'(f_op) == OP_SAMPLE) && oi_ok;
  assign q_req.neg   = f_cur[CUR_W-1];
  assign q_req.mag   = f_cur[MAG_W-1:0];
  assign q_req.step  = step_r;

  // newest-first lookup
  logic [8:0]    loc_t;
  logic [SW-1:0] loc_slot;
  logic          loc_found;
  assign loc_t     = 9'(next_slot_r) + 9'(EVENTS) - 9'd1 - 9'(f_idx);
  assign loc_slot  = (loc_t >= 9'(EVENTS)) ? SW'(loc_t - 9'(EVENTS)) : SW'(loc_t);
  assign loc_found = (9'(f_idx) < 9'(used_r)) && svalid_r[loc_slot];

  // data read bounds
  logic [EW-1:0] rd_cnt, rd_end;
  assign rd_cnt = (EW'(f_cnt) > EW'(MAX_READ)) ? EW'(MAX_READ) : EW'(f_cnt);
  assign rd_end = (EW'(f_off) + rd_cnt > EW'(TOTAL)) ? EW'(TOTAL) : EW'(f_off) + rd_cnt;

  // per-output views for the current item
  logic [SW-1:0]  cur_cslot;
  logic [CRW-1:0] cur_crem;
  logic [KW-1:0]  post_pos;
  assign cur_cslot = cslot_r[o_r];
  assign cur_crem  = crem_r[o_r];
  assign post_pos  = KW'(TOTAL) - KW'(cur_crem);

  logic [SW-1:0]     pk_addr;
  logic [CODE_W-1:0] pk_cur;
  assign pk_addr = (state_r == S_SWR) ? cur_cslot : slot_r;
  assign pk_cur  = speak_r[pk_addr];

  logic [RAW-1:0] ring_base;
  assign ring_base = RAW'(RAW'(o_r) * RAW'(PRE_SAMPLES));

  always_comb begin
    ring_we = 1'b0;
    ring_wa = clr_r;
    ring_wd = '0;
    if (state_r == S_INIT) begin
      ring_we = 1'b1;
    end else if (state_r == S_SWR) begin
      ring_we = 1'b1;
      ring_wa = ring_base + RAW'(head_r[o_r]);
      ring_wd = code_r;
    end
  end
  assign ring_ra = ring_base + RAW'(rp_r);

  always_comb begin
    st_we = 1'b0;
    st_wa = SAW'(SAW'(slot_r) * SAW'(TOTAL)) + SAW'(k_r);
    st_wd = '0;
    unique case (state_r)
      S_SWR: begin
        st_we = open_r[o_r] && (cur_crem != '0);
        st_wa = SAW'(SAW'(cur_cslot) * SAW'(TOTAL)) + SAW'(post_pos);
        st_wd = code_r;
      end
      S_TCOPY: begin
        st_we = wv_r;
        st_wa = SAW'(SAW'(slot_r) * SAW'(TOTAL)) + SAW'(wk_r);
        st_wd = ring_q;
      end
      S_TZERO: st_we = 1'b1;
      default: st_we = 1'b0;
    endcase
  end
  assign st_ra = SAW'(SAW'(slot_r) * SAW'(TOTAL)) + SAW'(pos_r);

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    ring_q <= ring_mem[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_q <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_r <= cfg_data;
    end
  end

  logic [PEAK_W-1:0] peak_prod;
  assign peak_prod = PEAK_W'(pk_cur) * PEAK_W'(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      next_slot_r <= '0;
      used_r      <= '0;
      for (int i = 0; i < OUTPUTS; i++) begin
        head_r[i]  <= '0;
        open_r[i]  <= 1'b0;
        cslot_r[i] <= '0;
        crem_r[i]  <= '0;
      end
      for (int j = 0; j < EVENTS; j++) svalid_r[j] <= 1'b0;
    end else begin
      unique case (state_r)
        S_INIT: begin
          clr_r <= clr_r + RAW'(1);
          if (32'(clr_r) == RING_D - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            o_r <= OW'(f_oi);
            priority case (op_t'(f_op))
              OP_SAMPLE: if (oi_ok) state_r <= S_QUANT;
              OP_TRIGGER: begin
                if (oi_ok && !open_r[OW'(f_oi)]) begin
                  slot_r      <= next_slot_r;
                  next_slot_r <= (32'(next_slot_r) == EVENTS - 1) ? '0
                                                                 : next_slot_r + SW'(1);
                  if (32'(used_r) < EVENTS) used_r <= used_r + UW'(1);
                  svalid_r[next_slot_r] <= 1'b1;
                  sout_r[next_slot_r]   <= f_oi;
                  sfs_r[next_slot_r]    <= f_fs;
                  slim_r[next_slot_r]   <= f_lim;
                  rp_r       <= head_r[OW'(f_oi)];
                  k_r        <= '0;
                  wv_r       <= 1'b0;
                  peak_acc_r <= '0;
                  state_r    <= S_TCOPY;
                end
              end
              OP_RD_HDR, OP_RD_DATA: begin
                slot_r <= loc_slot;
                pos_r  <= EW'(f_off);
                end_r  <= rd_end;
                if (!loc_found) begin
                  out_data_r  <= OUT_TDATA_W'({CNT_OUT_W'(used_r), 62'd0});
                  out_found_r <= 1'b0;
                  out_last_r  <= 1'b1;
                  out_valid_r <= 1'b1;
                  state_r     <= S_OUT;
                end else if (op_t'(f_op) == OP_RD_HDR) begin
                  state_r <= S_HDR;
                end else if (EW'(f_off) < rd_end) begin
                  state_r <= S_DRD;
                end
              end
              OP_CLEAR: begin
                next_slot_r <= '0;
                used_r      <= '0;
                for (int i = 0; i < OUTPUTS; i++) begin
                  head_r[i]  <= '0;
                  open_r[i]  <= 1'b0;
                  cslot_r[i] <= '0;
                  crem_r[i]  <= '0;
                end
                for (int j = 0; j < EVENTS; j++) svalid_r[j] <= 1'b0;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_QUANT: begin
          if (q_rsp.done) begin
            code_r  <= q_rsp.code;
            state_r <= S_SWR;
          end
        end
        S_SWR: begin
          head_r[o_r] <= (32'(head_r[o_r]) == PRE_SAMPLES - 1) ? '0
                                                               : head_r[o_r] + PW'(1);
          if (open_r[o_r]) begin
            if (cur_crem != '0) begin
              if (code_r > pk_cur) speak_r[cur_cslot] <= code_r;
              crem_r[o_r] <= cur_crem - CRW'(1);
            end
            if (cur_crem <= CRW'(1)) open_r[o_r] <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        S_TCOPY: begin
          // read issued one cycle, written the next
          if (32'(k_r) < PRE_SAMPLES) begin
            rp_r <= (32'(rp_r) == PRE_SAMPLES - 1) ? '0 : rp_r + PW'(1);
            k_r  <= k_r + KW'(1);
            wk_r <= k_r;
            wv_r <= 1'b1;
          end else begin
            wv_r <= 1'b0;
          end
          if (wv_r && ring_q > peak_acc_r) peak_acc_r <= ring_q;
          if (32'(k_r) == PRE_SAMPLES && !wv_r) state_r <= S_TZERO;
        end
        S_TZERO: begin
          k_r <= k_r + KW'(1);
          if (32'(k_r) == TOTAL - 1) begin
            speak_r[slot_r] <= peak_acc_r;
            open_r[o_r]     <= 1'b1;
            cslot_r[o_r]    <= slot_r;
            crem_r[o_r]     <= CRW'(POST_SAMPLES);
            state_r         <= S_IDLE;
          end
        end
        S_HDR: begin
          out_data_r  <= OUT_TDATA_W'({CNT_OUT_W'(used_r), 8'd0, peak_prod,
                                       slim_r[slot_r], sfs_r[slot_r], sout_r[slot_r]});
          out_found_r <= 1'b1;
          out_last_r  <= 1'b1;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_DRD: state_r <= S_DLOAD;
        S_DLOAD: begin
          out_data_r  <= OUT_TDATA_W'({CNT_OUT_W'(used_r), st_q, 54'd0});
          out_found_r <= 1'b1;
          out_last_r  <= (pos_r + EW'(1) == end_r);
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              pos_r   <= pos_r + EW'(1);
              state_r <= S_DRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_found_r;
  assign out_tlast    = out_last_r;

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while a result waits");

  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == (state_r == S_OUT)) else $error("result valid outside output state");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= EVENTS) else $error("event count above capacity");

  a_quant_done: assert property (@(posedge clk) disable iff (!rst_n)
    q_rsp.done |-> state_r == S_QUANT) else $error("quantizer result with no sample");

endmodule

`default_nettype wire

// File: sv/otr_quant.sv
// ---------------------------------------------------------------------------
// otr_quant
// Iterative quantizer: code = round(mag / step), clamped to 0..255, one
// restoring divide step per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module otr_quant
  import otr_pkg::*;
(
  input  wire    clk,
  input  wire    rst_n,
  input  q_req_t req,
  output q_rsp_t rsp
);

  logic              busy_r;
  logic              first_r;
  logic [2:0]        cnt_r;
  logic [20:0]       rem_r;
  logic [24:0]       dsh_r;
  logic [6:0]        q_r;
  logic              done_r;
  logic [CODE_W-1:0] code_r;

  logic [STEP_W-1:0] step1;
  logic [20:0]       num;
  logic [16:0]       den;
  logic              ge;

  assign step1 = (req.step == '0) ? STEP_W'(1) : req.step;
  // rounding: (2*mag + step) / (2*step)
  assign num   = {1'b0, req.mag, 1'b0} + 21'(step1);
  assign den   = {step1, 1'b0};
  assign ge    = ({4'b0, rem_r} >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.neg) begin
          done_r <= 1'b1;
          code_r <= '0;
        end else begin
          busy_r  <= 1'b1;
          first_r <= 1'b1;
          cnt_r   <= 3'd7;
          rem_r   <= num;
          dsh_r   <= {den, 8'b0};
          q_r     <= '0;
        end
      end else if (busy_r) begin
        if (first_r) begin
          // quotient of 256 or more saturates
          if (ge) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
            code_r <= CODE_MAX;
          end else begin
            first_r <= 1'b0;
            dsh_r   <= dsh_r >> 1;
          end
        end else begin
          if (ge) rem_r <= rem_r - dsh_r[20:0];
          q_r   <= {q_r[5:0], ge};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 3'd1;
          if (cnt_r == 3'd0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
            code_r <= {q_r, ge};
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.code = code_r;

endmodule

`default_nettype wire
